// File: design/lsps_pkg.sv
package lsps_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [1:0] REG_DERIV_GAIN  = 2'd1;
  localparam logic [1:0] REG_TOP_SPEED   = 2'd2;
  localparam logic [1:0] REG_FLOOR_SPEED = 2'd3;

  // register reset values
  localparam logic [7:0] PROP_GAIN_RST   = 8'd120;
  localparam logic [7:0] DERIV_GAIN_RST  = 8'd10;
  localparam logic [7:0] TOP_SPEED_RST   = 8'd255;
  localparam logic [7:0] FLOOR_SPEED_RST = 8'd0;

  typedef logic signed [3:0] err_t;

  // products of gain and error terms
  typedef struct packed {
    logic signed [12:0] p_term;
    logic signed [13:0] d_term;
    err_t               err;
  } terms_t;

  // map a sensor pattern to a position error, keep prev when unlisted
  function automatic err_t decode_pattern(input logic [5:0] pat, input err_t prev);
    err_t res;
    case (pat)
      6'b000001: res = -4'sd5;
      6'b000011: res = -4'sd4;
      6'b000010: res = -4'sd3;
      6'b000110: res = -4'sd2;
      6'b000100: res = -4'sd1;
      6'b001100: res = 4'sd0;
      6'b001000: res = 4'sd1;
      6'b011000: res = 4'sd2;
      6'b010000: res = 4'sd3;
      6'b110000: res = 4'sd4;
      6'b100000: res = 4'sd5;
      default:   res = prev;
    endcase
    return res;
  endfunction

  // clamp to top, then to floor (floor wins)
  function automatic logic [7:0] clamp_speed(input logic signed [13:0] v,
                                             input logic [7:0] top,
                                             input logic [7:0] floor_v);
    logic signed [13:0] t;
    t = v;
    if (t > $signed({6'd0, top}))
      t = $signed({6'd0, top});
    if (t < $signed({6'd0, floor_v}))
      t = $signed({6'd0, floor_v});
    return t[7:0];
  endfunction

endpackage

// File: design/line_sensor_pd_steering.sv
// Line sensor PD steering: each request carries one 6-bit sensor sample and
// yields one result with the left and right wheel speeds and the decoded
// position error. The block is a three-register pipeline (input register,
// gain-product register, result register) and takes one request per cycle
// unless the result side stalls it. The loop through the pattern decoder
// and the stored last error passes only the last-error register, so it
// allows that rate. Gains and speed limits are to be written through the
// configuration port only while the block is idle; it is not enforced.
module line_sensor_pd_steering (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // sensor requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] sensor_pattern,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] left_drive,
  output logic [7:0] right_drive,
  output logic [3:0] position_error
);

  logic [7:0] prop_gain;
  logic [7:0] deriv_gain;
  logic [7:0] top_speed;
  logic [7:0] floor_speed;

  logic       in_v;
  logic [5:0] in_pat;
  logic       mid_v;
  lsps_pkg::terms_t mid;
  lsps_pkg::err_t   last_error;
  lsps_pkg::terms_t mid_next;
  lsps_pkg::err_t   err_cur;
  logic signed [4:0]  err_diff;
  logic signed [13:0] pd;
  logic signed [13:0] left_raw;
  logic signed [13:0] right_raw;
  logic out_adv;
  logic mid_adv;
  logic in_adv;

  // pipeline advance conditions
  assign out_adv  = !out_valid || out_ready;
  assign mid_adv  = !mid_v || out_adv;
  assign in_adv   = !in_v || mid_adv;
  assign in_ready = in_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= lsps_pkg::PROP_GAIN_RST;
      deriv_gain  <= lsps_pkg::DERIV_GAIN_RST;
      top_speed   <= lsps_pkg::TOP_SPEED_RST;
      floor_speed <= lsps_pkg::FLOOR_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lsps_pkg::REG_PROP_GAIN:   prop_gain   <= cfg_data;
        lsps_pkg::REG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        lsps_pkg::REG_TOP_SPEED:   top_speed   <= cfg_data;
        lsps_pkg::REG_FLOOR_SPEED: floor_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_adv) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      in_pat <= sensor_pattern;
    end
  end

  // decode and gain products
  always_comb begin
    err_cur  = lsps_pkg::decode_pattern(in_pat, last_error);
    err_diff = 5'(err_cur) - 5'(last_error);
    mid_next.err    = err_cur;
    mid_next.p_term = $signed(13'({1'b0, prop_gain})) * 13'(err_cur);
    mid_next.d_term = $signed(14'({1'b0, deriv_gain})) * 14'(err_diff);
  end

  // last error follows each request leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
    end else if (in_v && mid_adv) begin
      last_error <= err_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_v <= 1'b0;
    end else if (mid_adv) begin
      mid_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv && in_v) begin
      mid <= mid_next;
    end
  end

  // pd sum and wheel speeds
  always_comb begin
    pd        = 14'(mid.p_term) + mid.d_term;
    left_raw  = $signed({6'd0, top_speed}) - pd;
    right_raw = $signed({6'd0, top_speed}) + pd;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= mid_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && mid_v) begin
      left_drive     <= lsps_pkg::clamp_speed(left_raw, top_speed, floor_speed);
      right_drive    <= lsps_pkg::clamp_speed(right_raw, top_speed, floor_speed);
      position_error <= mid.err;
    end
  end

  // speeds never fall below the floor
  a_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_drive >= floor_speed) && (right_drive >= floor_speed))
    else $error("speed below floor");

  // speeds stay at or under top when the floor allows it
  a_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && (floor_speed <= top_speed) |->
      (left_drive <= top_speed) && (right_drive <= top_speed))
    else $error("speed above top");

  // decoded error stays within the table range
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(position_error) >= -4'sd5) && ($signed(position_error) <= 4'sd5))
    else $error("position error out of range");

  // stored error stays within the table range
  a_last: assert property (@(posedge clk) disable iff (rst)
    (last_error >= -4'sd5) && (last_error <= 4'sd5))
    else $error("last error out of range");

endmodule

// File: dv/tb_line_sensor_pd_steering.sv
`timescale 1ns / 1ps

module tb_line_sensor_pd_steering;

  // expected result of one sensor request
  typedef struct {
    logic [7:0]     left;
    logic [7:0]     right;
    lsps_pkg::err_t err;
  } steer_t;

  // steering predictor and the queue of speeds it expects
  class steer_scoreboard;
    int          prop_gain;
    int          deriv_gain;
    int          top_speed;
    int          floor_speed;
    int          last_err;
    steer_t      steer_q[$];
    int unsigned errors;
    int unsigned matched;

    function new();
      prop_gain   = int'(lsps_pkg::PROP_GAIN_RST);
      deriv_gain  = int'(lsps_pkg::DERIV_GAIN_RST);
      top_speed   = int'(lsps_pkg::TOP_SPEED_RST);
      floor_speed = int'(lsps_pkg::FLOOR_SPEED_RST);
      last_err    = 0;
      errors      = 0;
      matched     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        lsps_pkg::REG_PROP_GAIN:   prop_gain = int'(val);
        lsps_pkg::REG_DERIV_GAIN:  deriv_gain = int'(val);
        lsps_pkg::REG_TOP_SPEED:   top_speed = int'(val);
        lsps_pkg::REG_FLOOR_SPEED: floor_speed = int'(val);
        default: ;
      endcase
    endfunction

    // line position from the sensor row, unknown rows hold the last one
    function int line_position(logic [5:0] pat);
      case (pat)
        6'h01:   return -5;
        6'h03:   return -4;
        6'h02:   return -3;
        6'h06:   return -2;
        6'h04:   return -1;
        6'h0C:   return 0;
        6'h08:   return 1;
        6'h18:   return 2;
        6'h10:   return 3;
        6'h30:   return 4;
        6'h20:   return 5;
        default: return last_err;
      endcase
    endfunction

    // top clamp first, floor clamp wins
    function logic [7:0] limit_speed(int v);
      int t;
      t = v;
      if (t > top_speed) t = top_speed;
      if (t < floor_speed) t = floor_speed;
      return t[7:0];
    endfunction

    function void note_request(logic [5:0] pat);
      int     err;
      int     pd;
      steer_t s;
      err     = line_position(pat);
      pd      = prop_gain * err + deriv_gain * (err - last_err);
      s.left  = limit_speed(top_speed - pd);
      s.right = limit_speed(top_speed + pd);
      s.err   = err[3:0];
      last_err = err;
      steer_q.push_back(s);
    endfunction

    function void check_result(logic [7:0] left, logic [7:0] right, logic [3:0] err);
      steer_t s;
      if (steer_q.size() == 0) begin
        $error("result with no request waiting: left %0d right %0d", left, right);
        errors++;
        return;
      end
      s = steer_q.pop_front();
      if (left !== s.left) begin
        $error("left_drive mismatch: expected %0d actual %0d", s.left, left);
        errors++;
      end
      if (right !== s.right) begin
        $error("right_drive mismatch: expected %0d actual %0d", s.right, right);
        errors++;
      end
      if (err !== s.err) begin
        $error("position_error mismatch: expected %0d actual %0d",
               $signed(s.err), $signed(err));
        errors++;
      end
      matched++;
    endfunction

    function int pending();
      return steer_q.size();
    endfunction

    function void drain_check();
      if (steer_q.size() != 0) begin
        $error("%0d expected results never arrived", steer_q.size());
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [5:0] sensor_pattern;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] left_drive;
  logic [7:0] right_drive;
  logic [3:0] position_error;

  steer_scoreboard sb;
  bit              no_idle;
  int unsigned     req_count;
  int unsigned     setting_count;
  int unsigned     quiet_cycles;
  int unsigned     stall_left;
  int              walk_pos;

  // sensor rows ordered from error -5 to +5
  logic [5:0] line_row [11] = '{6'h01, 6'h03, 6'h02, 6'h06, 6'h04, 6'h0C,
                                6'h08, 6'h18, 6'h10, 6'h30, 6'h20};

  line_sensor_pd_steering DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sensor_pattern(sensor_pattern),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .position_error(position_error)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random gap between requests, mostly short
  function int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle) begin
        int r;
        r = $urandom_range(0, 99);
        if (r >= 95) stall_left <= $urandom_range(10, 40);
        else if (r >= 70) stall_left <= $urandom_range(1, 3);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(left_drive, right_drive, position_error);
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", sb.pending());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // one sensor request; called and returns at a falling edge
  task automatic send_sample(input logic [5:0] pat);
    int gap;
    in_valid       <= 1'b1;
    sensor_pattern <= pat;
    do @(posedge clk); while (!in_ready);
    sb.note_request(pat);
    req_count++;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    sb.set_reg(idx, val);
  endtask

  // wait for the pipeline to empty, then load all four registers
  task automatic load_settings(input logic [7:0] kp, input logic [7:0] kd,
                               input logic [7:0] top, input logic [7:0] flr);
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    put_reg(lsps_pkg::REG_PROP_GAIN, kp);
    put_reg(lsps_pkg::REG_DERIV_GAIN, kd);
    put_reg(lsps_pkg::REG_TOP_SPEED, top);
    put_reg(lsps_pkg::REG_FLOOR_SPEED, flr);
    cfg_we <= 1'b0;
    @(negedge clk);
    setting_count++;
  endtask

  // random requests: mostly a line drifting under the sensors, some noise
  task automatic send_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        walk_pos += int'($urandom_range(0, 4)) - 2;
        if (walk_pos < 0) walk_pos = 0;
        if (walk_pos > 10) walk_pos = 10;
        send_sample(line_row[walk_pos]);
      end else if (r < 80) begin
        walk_pos = $urandom_range(0, 10);
        send_sample(line_row[walk_pos]);
      end else if (r < 85) begin
        send_sample($urandom_range(0, 1) ? 6'h3F : 6'h00);
      end else begin
        send_sample(6'($urandom_range(0, 63)));
      end
    end
    end_burst();
  endtask

  initial begin
    logic [7:0] kp, kd, top, flr;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    sensor_pattern = '0;
    req_count      = 0;
    setting_count  = 0;
    walk_pos       = 5;
    no_idle        = 1'b0;
    sb             = new();

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset gains: sweep every table row, then unknown rows and a hard swing
    for (int i = 0; i < 11; i++) send_sample(line_row[i]);
    send_sample(6'h00);
    send_sample(6'h3F);
    send_sample(6'h2A);
    send_sample(6'h01);
    send_sample(6'h20);
    end_burst();

    // largest gains push both speeds past their limits
    load_settings(8'd255, 8'd255, 8'd255, 8'd0);
    send_sample(6'h01);
    send_sample(6'h20);
    send_sample(6'h15);
    send_sample(6'h01);
    end_burst();

    // floor above top forces both speeds to the floor
    load_settings(8'd7, 8'd3, 8'd10, 8'd200);
    send_sample(6'h20);
    send_sample(6'h0C);
    send_sample(6'h01);
    end_burst();

    // zero gains and zero limits
    load_settings(8'd0, 8'd0, 8'd0, 8'd0);
    send_sample(6'h01);
    send_sample(6'h20);
    end_burst();

    // random phases, extremes first, some with no idling at all
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin kp = 8'd255; kd = 8'd255; top = 8'd255; flr = 8'd255; end
        1: begin kp = 8'd0;   kd = 8'd255; top = 8'd128; flr = 8'd0;   end
        2: begin kp = 8'd1;   kd = 8'd0;   top = 8'd255; flr = 8'd250; end
        default: begin
          kp  = 8'($urandom_range(0, 255));
          kd  = 8'($urandom_range(0, 255));
          top = 8'($urandom_range(0, 255));
          flr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 40));
        end
      endcase
      no_idle = (ph % 3 == 2);
      load_settings(kp, kd, top, flr);
      send_random(135);
    end
    no_idle = 1'b0;

    // drain and let the pipeline settle
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    sb.drain_check();

    $display("sent %0d sensor requests under %0d gain and speed settings",
             req_count, setting_count);
    $display("checked %0d results, %0d errors", sb.matched, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/lsps_pkg.sv
design/line_sensor_pd_steering.sv
dv/tb_line_sensor_pd_steering.sv
